// ----- design/llfifo_pkg.sv -----
// Shared types and codes for the linked-list FIFO with free list.
// Holds the request and response payload structs and the operation and status codes.
// Has no dependencies.
package llfifo_pkg;

	localparam int unsigned FIELD_DATA_W = 32;
	localparam int unsigned COUNT_W      = 8;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]              operation;
		logic [FIELD_DATA_W-1:0] push_data;
	} req_t;

	typedef struct packed {
		logic [FIELD_DATA_W-1:0] read_data;
		logic [1:0]              status;
		logic [COUNT_W-1:0]      element_count;
	} rsp_t;

endpackage

// ----- design/llfifo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies; storage has no reset.
module llfifo_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/llfifo_core.sv -----
// Request register, list pointers and per-request update logic.
// Depends on llfifo_pkg; drives the write and read ports of the external RAMs.
module llfifo_core #(
	parameter int unsigned QUEUE_DEPTH = 128,
	parameter int unsigned DATA_WIDTH  = 32,
	localparam int unsigned AW = $clog2(QUEUE_DEPTH),
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  llfifo_pkg::req_t      req,
	input  logic                  rsp_ready,
	output logic                  commit,
	output llfifo_pkg::rsp_t      result,
	output logic                  elem_we,
	output logic [AW-1:0]         elem_waddr,
	output logic [DATA_WIDTH-1:0] elem_wdata,
	output logic [AW-1:0]         elem_raddr,
	input  logic [DATA_WIDTH-1:0] elem_rdata,
	output logic                  link_we,
	output logic [AW-1:0]         link_waddr,
	output logic [AW-1:0]         link_wdata,
	output logic [AW-1:0]         front_raddr,
	input  logic [AW-1:0]         front_link_rdata,
	output logic [AW-1:0]         free_raddr,
	input  logic [AW-1:0]         free_link_rdata
);

	logic             pend_s1;
	llfifo_pkg::req_t req_s1;
	logic [AW-1:0]    front_q, back_q, free_head_q;
	logic [CW-1:0]    count_q, mark_q;

	logic [AW-1:0]    front_d, back_d, free_head_d;
	logic [CW-1:0]    count_d, mark_d;
	logic [AW-1:0]    front_link, free_link;
	logic [31:0]      elem_ext;

	// slots at or above the mark were never allocated: their link is taken as index + 1, wrapping to 0
	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		next_slot = (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign req_stall   = pend_s1;
	assign commit      = pend_s1 && rsp_ready;
	assign elem_raddr  = front_q;
	assign front_raddr = front_q;
	assign free_raddr  = free_head_q;
	assign elem_ext    = 32'(elem_rdata);
	assign elem_wdata  = DATA_WIDTH'(req_s1.push_data);
	assign elem_waddr  = free_head_q;

	assign front_link = (CW'(front_q) >= mark_q) ? next_slot(front_q) : front_link_rdata;
	assign free_link  = (CW'(free_head_q) >= mark_q) ? next_slot(free_head_q) : free_link_rdata;

	always_comb begin
		front_d              = front_q;
		back_d               = back_q;
		free_head_d          = free_head_q;
		count_d              = count_q;
		mark_d               = mark_q;
		elem_we              = 1'b0;
		link_we              = 1'b0;
		link_waddr           = back_q;
		link_wdata           = free_head_q;
		result.read_data     = '0;
		result.status        = llfifo_pkg::ST_OK;
		case (req_s1.operation)
			llfifo_pkg::OP_PUSH: begin
				if (count_q == CW'(QUEUE_DEPTH)) begin
					result.status = llfifo_pkg::ST_FULL;
				end else begin
					elem_we = commit;
					if (count_q == '0) begin
						front_d = free_head_q;
					end else begin
						link_we = commit;
					end
					back_d      = free_head_q;
					free_head_d = free_link;
					count_d     = count_q + 1'b1;
					if (CW'(free_head_q) == mark_q) begin
						mark_d = mark_q + 1'b1;
					end
				end
			end
			llfifo_pkg::OP_POP: begin
				if (count_q == '0) begin
					result.status = llfifo_pkg::ST_EMPTY;
				end else begin
					result.read_data = elem_ext;
					front_d          = front_link;
					link_we          = commit;
					link_waddr       = front_q;
					free_head_d      = front_q;
					count_d          = count_q - 1'b1;
				end
			end
			llfifo_pkg::OP_PEEK: begin
				if (count_q == '0) begin
					result.status = llfifo_pkg::ST_EMPTY;
				end else begin
					result.read_data = elem_ext;
				end
			end
			default: begin
			end
		endcase
		result.element_count = 8'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			front_q     <= '0;
			back_q      <= '0;
			free_head_q <= '0;
			count_q     <= '0;
			mark_q      <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				pend_s1 <= 1'b1;
			end else if (commit) begin
				pend_s1 <= 1'b0;
			end
			if (commit) begin
				front_q     <= front_d;
				back_q      <= back_d;
				free_head_q <= free_head_d;
				count_q     <= count_d;
				mark_q      <= mark_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

endmodule

// ----- design/llfifo_out.sv -----
// Response register: holds one result until the consumer takes it.
// Depends on llfifo_pkg for the response struct.
module llfifo_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  llfifo_pkg::rsp_t din,
	output logic             ready,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output llfifo_pkg::rsp_t rsp
);

	logic             valid_q;
	llfifo_pkg::rsp_t rsp_q;

	assign ready     = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			rsp_q <= din;
		end
	end

endmodule

// ----- design/linked_list_fifo_with_free_list_top.sv -----
// Top level of the linked-list FIFO with free list.
// Depends on llfifo_pkg, llfifo_ram, llfifo_core and llfifo_out.
// Each request (push, pop or peek) is first registered while the element and link
// RAMs are read at the front and free-list head slots; once the response register can
// take a result, the core updates the pointers, writes the RAMs and loads the response
// register. A new request is taken on the cycle after the previous one commits, even
// while its response is still held on the output.
// Every request yields exactly one response carrying the element count after the
// operation. Popping or peeking an empty queue returns empty status, pushing onto a
// full queue returns full status. No clearing pass is needed after reset.
module linked_list_fifo_with_free_list_top #(
	parameter int unsigned QUEUE_DEPTH = 128,
	parameter int unsigned DATA_WIDTH  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  llfifo_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output llfifo_pkg::rsp_t rsp
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	logic                  rsp_ready, commit;
	llfifo_pkg::rsp_t      result;
	logic                  elem_we, link_we;
	logic [AW-1:0]         elem_waddr, elem_raddr, link_waddr, link_wdata;
	logic [AW-1:0]         front_raddr, free_raddr, front_link_rdata, free_link_rdata;
	logic [DATA_WIDTH-1:0] elem_wdata, elem_rdata;

	llfifo_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_ready       (rsp_ready),
		.commit          (commit),
		.result          (result),
		.elem_we         (elem_we),
		.elem_waddr      (elem_waddr),
		.elem_wdata      (elem_wdata),
		.elem_raddr      (elem_raddr),
		.elem_rdata      (elem_rdata),
		.link_we         (link_we),
		.link_waddr      (link_waddr),
		.link_wdata      (link_wdata),
		.front_raddr     (front_raddr),
		.front_link_rdata(front_link_rdata),
		.free_raddr      (free_raddr),
		.free_link_rdata (free_link_rdata)
	);

	llfifo_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_elem_ram (
		.clk  (clk),
		.we   (elem_we),
		.waddr(elem_waddr),
		.wdata(elem_wdata),
		.raddr(elem_raddr),
		.rdata(elem_rdata)
	);

	// two copies of the link store, one read port each
	llfifo_ram #(
		.WIDTH(AW),
		.DEPTH(QUEUE_DEPTH)
	) u_front_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(front_raddr),
		.rdata(front_link_rdata)
	);

	llfifo_ram #(
		.WIDTH(AW),
		.DEPTH(QUEUE_DEPTH)
	) u_free_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(free_raddr),
		.rdata(free_link_rdata)
	);

	llfifo_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (commit),
		.din      (result),
		.ready    (rsp_ready),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ----- design/llfifo_chk.sv -----
// Port-level checker for the linked-list FIFO top level, attached by bind.
// Depends on llfifo_pkg for the status codes.
module llfifo_chk #(
	parameter int unsigned QUEUE_DEPTH = 128
) (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input llfifo_pkg::req_t req,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input llfifo_pkg::rsp_t rsp
);

	// held response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in flight: stall follows every accepted request
	a_req_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != llfifo_pkg::ST_OK |-> rsp.read_data == '0)
		else $error("error response carries data");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == llfifo_pkg::ST_EMPTY |-> rsp.element_count == '0)
		else $error("empty status with nonzero count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == llfifo_pkg::ST_FULL |->
		rsp.element_count == 8'(QUEUE_DEPTH))
		else $error("full status with count below depth");

endmodule

bind linked_list_fifo_with_free_list_top llfifo_chk #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_llfifo_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
